// ===== hw/rtl/mrcs_pkg.sv =====
package mrcs_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SWAP_ROWS = 2'd1;
    localparam logic [1:0] OP_SWAP_COLS = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // size registers come out of reset at 64
    localparam logic [6:0] SIZE_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ELEM_WAIT,
        S_SWAP_WA,
        S_SWAP_WB,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;    // capture input word, clear pair counter
        logic res_init;     // result value 0, error flag from range check
        logic elem_wr;      // store the element write
        logic rd_issue;     // read the element or the current pair
        logic rd_next;      // pair read uses counter plus one
        logic wr_p;         // write first cell of pair with second's data
        logic wr_q;         // write second cell of pair with first's data
        logic cnt_inc;      // advance pair counter
        logic res_capture;  // result value from read data
        logic out_load;     // move result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       err;
        logic       same;
        logic       last;
        logic       out_free;
    } t_status;

endpackage

// ===== hw/rtl/mrcs_ctrl.sv =====
module mrcs_ctrl
    import mrcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.err) begin
                    n_state = S_DONE;
                end else begin
                    case (i_status.op)
                        OP_WRITE: n_state = S_DONE;
                        OP_READ:  n_state = S_ELEM_WAIT;
                        default:  n_state = i_status.same ? S_DONE : S_SWAP_WA;
                    endcase
                end
            end
            S_ELEM_WAIT: n_state = S_DONE;
            S_SWAP_WA:   n_state = S_SWAP_WB;
            S_SWAP_WB: begin
                n_state = i_status.last ? S_DONE : S_SWAP_WA;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.load_item = i_valid;
            end
            S_DECODE: begin
                o_cmd.res_init = 1'b1;
                if (!i_status.err) begin
                    case (i_status.op)
                        OP_WRITE: o_cmd.elem_wr = 1'b1;
                        OP_READ:  o_cmd.rd_issue = 1'b1;
                        default:  o_cmd.rd_issue = !i_status.same;
                    endcase
                end
            end
            S_ELEM_WAIT: o_cmd.res_capture = 1'b1;
            S_SWAP_WA:   o_cmd.wr_p = 1'b1;
            S_SWAP_WB: begin
                o_cmd.wr_q = 1'b1;
                if (!i_status.last) begin
                    o_cmd.rd_issue = 1'b1;
                    o_cmd.rd_next  = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                end
            end
            S_DONE: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/mrcs_datapath.sv =====
module mrcs_datapath
    import mrcs_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic [1:0] i_opcode,
    input  logic [6:0] i_index_a,
    input  logic [6:0] i_index_b,
    input  logic [7:0] i_value,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_read_value,
    output logic       o_index_error,
    input  t_cmd       i_cmd,
    output t_status    o_status
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam logic [8:0] MAX_W = 9'(MAX_DIM);

    logic [6:0] r_rows;
    logic [6:0] r_cols;
    logic [1:0] r_op;
    logic [6:0] r_a;
    logic [6:0] r_b;
    logic [7:0] r_v;
    logic [CW-1:0] r_cnt;
    logic [7:0] r_dp;
    logic [7:0] r_dq;
    logic [7:0] r_res_val;
    logic       r_res_err;
    logic       r_out_valid;
    logic [7:0] r_out_val;
    logic       r_out_err;

    logic [7:0] mem [DEPTH];

    logic a_row_ok;
    logic b_row_ok;
    logic a_col_ok;
    logic b_col_ok;
    logic [CW-1:0] eff_rows;
    logic [CW-1:0] eff_cols;
    logic [CW-1:0] limit;
    logic [CW-1:0] cnt_rd;
    logic [IW-1:0] idx_a;
    logic [IW-1:0] idx_b;
    logic [AW-1:0] rd_p;
    logic [AW-1:0] rd_q;
    logic [AW-1:0] wr_p;
    logic [AW-1:0] wr_q;
    logic [8:0]    a_ext;
    logic [8:0]    b_ext;
    logic          err;

    // cell address of one side of a pair; for element access the first side is (a, b)
    function automatic logic [AW-1:0] cell_addr(input logic [1:0] op,
                                                input logic [IW-1:0] x,
                                                input logic [IW-1:0] y,
                                                input logic [IW-1:0] i);
        logic [AW-1:0] addr;
        case (op)
            OP_SWAP_ROWS: addr = {x, i};
            OP_SWAP_COLS: addr = {i, x};
            default:      addr = {x, y};
        endcase
        return addr;
    endfunction

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SIZE_RESET;
            r_cols <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  r_rows <= r_rows;
            endcase
        end
    end

    // range checks against the size in use (clamped to the store)
    assign a_ext = {2'b00, r_a};
    assign b_ext = {2'b00, r_b};
    assign a_row_ok = (r_a < r_rows) && (a_ext < MAX_W);
    assign b_row_ok = (r_b < r_rows) && (b_ext < MAX_W);
    assign a_col_ok = (r_a < r_cols) && (a_ext < MAX_W);
    assign b_col_ok = (r_b < r_cols) && (b_ext < MAX_W);

    always_comb begin
        case (r_op)
            OP_SWAP_ROWS: err = !(a_row_ok && b_row_ok && (r_cols != 7'd0));
            OP_SWAP_COLS: err = !(a_col_ok && b_col_ok && (r_rows != 7'd0));
            default:      err = !(a_row_ok && b_col_ok);
        endcase
    end

    assign eff_rows = ({2'b00, r_rows} > MAX_W) ? CW'(MAX_DIM) : CW'(r_rows);
    assign eff_cols = ({2'b00, r_cols} > MAX_W) ? CW'(MAX_DIM) : CW'(r_cols);
    assign limit    = (r_op == OP_SWAP_ROWS) ? eff_cols : eff_rows;

    // addresses: reads may run one pair ahead of the writes
    assign idx_a  = a_ext[IW-1:0];
    assign idx_b  = b_ext[IW-1:0];
    assign cnt_rd = i_cmd.rd_next ? r_cnt + CW'(1) : r_cnt;
    assign rd_p   = cell_addr(r_op, idx_a, idx_b, cnt_rd[IW-1:0]);
    assign rd_q   = cell_addr(r_op, idx_b, idx_b, cnt_rd[IW-1:0]);
    assign wr_p   = cell_addr(r_op, idx_a, idx_b, r_cnt[IW-1:0]);
    assign wr_q   = cell_addr(r_op, idx_b, idx_b, r_cnt[IW-1:0]);

    // captured word and pair counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op <= i_opcode;
            r_a  <= i_index_a;
            r_b  <= i_index_b;
            r_v  <= i_value;
        end
        if (i_cmd.load_item) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // matrix store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.elem_wr) begin
            mem[wr_p] <= r_v;
        end else if (i_cmd.wr_p) begin
            mem[wr_p] <= r_dq;
        end else if (i_cmd.wr_q) begin
            mem[wr_q] <= r_dp;
        end
        if (i_cmd.rd_issue) begin
            r_dp <= mem[rd_p];
            r_dq <= mem[rd_q];
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_init) begin
            r_res_val <= 8'd0;
            r_res_err <= err;
        end else if (i_cmd.res_capture) begin
            r_res_val <= r_dp;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_val <= r_res_val;
            r_out_err <= r_res_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_val;
    assign o_index_error = r_out_err;

    assign o_status.op       = r_op;
    assign o_status.err      = err;
    assign o_status.same     = (r_a == r_b);
    assign o_status.last     = (r_cnt == limit - CW'(1));
    assign o_status.out_free = !r_out_valid || i_ready;

endmodule

// ===== hw/rtl/matrix_row_column_swap.sv =====
// Byte matrix with element write/read and whole row or column exchange, held
// in a store of MAX_DIM by MAX_DIM bytes addressed as {row, column}. One word
// is taken at a time and each gives one result word. After decode, an element
// write, a flagged word or a swap of an index with itself goes straight to the
// done state; an element read passes through an element wait state; a swap
// over n elements (n is cols_in_use for a row swap, rows_in_use for a column
// swap, clamped to MAX_DIM) steps through the two write states once per pair.
// The done state moves the result into the output register once it is free.
// Because the store has a single write port, each pair is written in two
// states, S_SWAP_WA then S_SWAP_WB, with the read of the next pair overlapped
// on the second. The next word is accepted as soon as the result sits in the
// output register, even if it has not yet been taken. The user must write the
// size registers only while idle; the block itself does not enforce it.
module matrix_row_column_swap
    import mrcs_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [6:0] i_index_a,
    input  logic [6:0] i_index_b,
    input  logic [7:0] i_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_value,
    output logic       o_index_error
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    mrcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // store, range checks and result path
    mrcs_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_index_a     (i_index_a),
        .i_index_b     (i_index_b),
        .i_value       (i_value),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_index_error (o_index_error),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule
